FILE: rtl/csvt_pkg.sv
// shared types and constants for the csv record tokenizer
// no dependencies
package csvt_pkg;

    localparam int unsigned FIELD_CAPACITY_DEF = 4096;
    localparam int unsigned MAX_FIELDS         = 16;
    localparam int unsigned QUEUE_DEPTH        = 4;

    localparam int unsigned CFG_INDEX_W    = 4;
    localparam int unsigned CFG_DATA_W     = 13;
    localparam int unsigned CFG_EXPECTED_W = 5;
    localparam int unsigned CFG_LIMIT_W    = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT    = 4'd1;

    localparam logic [CFG_EXPECTED_W-1:0] EXPECTED_RST = 5'd5;
    localparam logic [CFG_LIMIT_W-1:0]    LIMIT_RST    = 13'd4096;

    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_SEP    = 2'd1;
    localparam logic [1:0] KIND_ACCEPT = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] col;
        logic [7:0] ch;
    } res_t;

    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } entry_t;

    function automatic logic is_end(input logic [7:0] b);
        return (b == CH_LF) || (b == CH_NUL);
    endfunction

endpackage

FILE: rtl/csvt_front.sv
// front end: config registers, byte classification and record state
// depends on csvt_pkg; pushes at most one entry, of up to two results, per byte
module csvt_front
    import csvt_pkg::*;
#(
    parameter int unsigned FIELD_CAPACITY = FIELD_CAPACITY_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_in_byte,
    input  logic                   q_full,
    output logic                   push,
    output entry_t                 push_entry
);

    localparam int unsigned LEN_W = $clog2(FIELD_CAPACITY + 1);
    localparam int unsigned CMP_W = ((LEN_W > CFG_LIMIT_W) ? LEN_W : CFG_LIMIT_W) + 1;
    localparam logic [CMP_W-1:0] CAP = CMP_W'(FIELD_CAPACITY);

    typedef struct packed {
        logic             quoted;
        logic             after_cq;
        logic             at_fs;
        logic [3:0]       col;
        logic [LEN_W-1:0] len;
        logic             pq;
        logic             pcr;
        logic             disc;
    } fst_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } step_t;

    logic [CFG_EXPECTED_W-1:0] expected_reg;
    logic [CFG_LIMIT_W-1:0]    limit_reg;
    fst_t                      st_reg, st_next;
    logic [CFG_EXPECTED_W-1:0] eff_exp;
    logic [CMP_W-1:0]          eff_lim;
    logic                      fire;
    step_t                     step;

    function automatic void emit(inout step_t p, input logic [1:0] k,
                                 input logic [3:0] c, input logic [7:0] ch);
        if (p.n == 2'd0) begin
            p.r0 = '{kind: k, col: c, ch: ch};
            p.n  = 2'd1;
        end else if (p.n == 2'd1) begin
            p.r1 = '{kind: k, col: c, ch: ch};
            p.n  = 2'd2;
        end
    endfunction

    function automatic void new_record(inout fst_t s);
        s.quoted   = 1'b0;
        s.after_cq = 1'b0;
        s.at_fs    = 1'b1;
        s.col      = '0;
        s.len      = '0;
        s.pq       = 1'b0;
        s.pcr      = 1'b0;
    endfunction

    function automatic void reject(inout fst_t s, inout step_t p, input logic at_end);
        emit(p, KIND_REJECT, s.col, 8'd0);
        new_record(s);
        s.disc = !at_end;
    endfunction

    function automatic logic put_char(inout fst_t s, inout step_t p,
                                      input logic [7:0] c, input logic [CMP_W-1:0] lim);
        if (CMP_W'(s.len) + CMP_W'(1) >= lim) begin
            reject(s, p, 1'b0);
            return 1'b0;
        end
        emit(p, KIND_CHAR, s.col, c);
        s.len   = s.len + LEN_W'(1);
        s.at_fs = 1'b0;
        return 1'b1;
    endfunction

    function automatic void end_record(inout fst_t s, inout step_t p,
                                       input logic [CFG_EXPECTED_W-1:0] ex);
        if (CFG_EXPECTED_W'(s.col) + CFG_EXPECTED_W'(1) == ex) begin
            emit(p, KIND_ACCEPT, s.col, 8'd0);
        end else begin
            emit(p, KIND_REJECT, s.col, 8'd0);
        end
        new_record(s);
        s.disc = 1'b0;
    endfunction

    function automatic void unquoted(inout fst_t s, inout step_t p, input logic [7:0] b,
                                     input logic [CMP_W-1:0] lim,
                                     input logic [CFG_EXPECTED_W-1:0] ex);
        if (s.after_cq && b != CH_COMMA && b != CH_CR && !is_end(b)) begin
            reject(s, p, 1'b0);
        end else if (b == CH_QUOTE) begin
            if (!s.at_fs) begin
                reject(s, p, 1'b0);
            end else begin
                s.quoted = 1'b1;
                s.at_fs  = 1'b0;
            end
        end else if (b == CH_COMMA) begin
            if (CFG_EXPECTED_W'(s.col) + CFG_EXPECTED_W'(1) >= ex) begin
                reject(s, p, 1'b0);
            end else begin
                emit(p, KIND_SEP, s.col, 8'd0);
                s.col      = s.col + 4'd1;
                s.len      = '0;
                s.at_fs    = 1'b1;
                s.after_cq = 1'b0;
            end
        end else if (b == CH_CR) begin
            s.pcr = 1'b1;
        end else if (is_end(b)) begin
            end_record(s, p, ex);
        end else begin
            void'(put_char(s, p, b, lim));
        end
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign fire      = s_valid && s_ready;

    always_comb begin
        if (expected_reg == '0) begin
            eff_exp = CFG_EXPECTED_W'(1);
        end else if (expected_reg > CFG_EXPECTED_W'(MAX_FIELDS)) begin
            eff_exp = CFG_EXPECTED_W'(MAX_FIELDS);
        end else begin
            eff_exp = expected_reg;
        end
        if (CMP_W'(limit_reg) > CAP) begin
            eff_lim = CAP;
        end else begin
            eff_lim = CMP_W'(limit_reg);
        end
    end

    always_comb begin
        fst_t  s;
        step_t p;
        s = st_reg;
        p = '0;
        if (s.disc) begin
            if (is_end(s_in_byte)) begin
                s.disc = 1'b0;
                new_record(s);
            end
        end else if (s.pq) begin
            s.pq = 1'b0;
            if (s_in_byte == CH_QUOTE) begin
                void'(put_char(s, p, CH_QUOTE, eff_lim));
            end else begin
                s.quoted   = 1'b0;
                s.after_cq = 1'b1;
                unquoted(s, p, s_in_byte, eff_lim, eff_exp);
            end
        end else if (s.pcr) begin
            s.pcr = 1'b0;
            if (is_end(s_in_byte)) begin
                end_record(s, p, eff_exp);
            end else if (s.after_cq) begin
                reject(s, p, 1'b0);
            end else if (put_char(s, p, CH_CR, eff_lim)) begin
                unquoted(s, p, s_in_byte, eff_lim, eff_exp);
            end
        end else if (s.quoted) begin
            if (is_end(s_in_byte)) begin
                reject(s, p, 1'b1);
            end else if (s_in_byte == CH_QUOTE) begin
                s.pq = 1'b1;
            end else begin
                void'(put_char(s, p, s_in_byte, eff_lim));
            end
        end else begin
            unquoted(s, p, s_in_byte, eff_lim, eff_exp);
        end
        step    = p;
        st_next = fire ? s : st_reg;
    end

    assign push            = fire && (step.n != 2'd0);
    assign push_entry.two  = (step.n == 2'd2);
    assign push_entry.r0   = step.r0;
    assign push_entry.r1   = step.r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg <= EXPECTED_RST;
            limit_reg    <= LIMIT_RST;
            st_reg       <= '{quoted: 1'b0, after_cq: 1'b0, at_fs: 1'b1, col: '0,
                              len: '0, pq: 1'b0, pcr: 1'b0, disc: 1'b0};
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_EXPECTED) begin
                    expected_reg <= cfg_data[CFG_EXPECTED_W-1:0];
                end else if (cfg_index == REG_LIMIT) begin
                    limit_reg <= cfg_data[CFG_LIMIT_W-1:0];
                end
            end
            st_reg <= st_next;
        end
    end

endmodule

FILE: rtl/csvt_queue.sv
// short word queue between the front and back ends
// depends on csvt_pkg for the entry type and depth
module csvt_queue
    import csvt_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    output logic   q_valid,
    output entry_t q_entry,
    input  logic   pop
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + PTR_W'(1);
    endfunction

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid) else $error("queue pop while empty");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not advance");
`endif

endmodule

FILE: rtl/csvt_back.sv
// back end: unpacks queue entries into single result words
// depends on csvt_pkg; holds the output register and the second result
module csvt_back
    import csvt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  entry_t     q_entry,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [3:0] m_column_index,
    output logic [7:0] m_character,
    output logic       m_last_of_step
);

    logic m_valid_reg;
    res_t out_reg;
    logic last_reg;
    res_t second_reg;
    logic second_pend_reg;
    logic load;

    assign load = !m_valid_reg || m_ready;
    assign pop  = load && !second_pend_reg && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            second_pend_reg <= 1'b0;
        end else if (load) begin
            if (second_pend_reg) begin
                m_valid_reg     <= 1'b1;
                second_pend_reg <= 1'b0;
            end else begin
                m_valid_reg     <= q_valid;
                second_pend_reg <= q_valid && q_entry.two;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (second_pend_reg) begin
                out_reg  <= second_reg;
                last_reg <= 1'b1;
            end else begin
                out_reg    <= q_entry.r0;
                last_reg   <= !q_entry.two;
                second_reg <= q_entry.r1;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_column_index = out_reg.col;
    assign m_character    = out_reg.ch;
    assign m_last_of_step = last_reg;

`ifndef SYNTHESIS
    a_second_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        second_pend_reg |-> (m_valid_reg && !last_reg))
        else $error("second result pending without a first in the output register");
`endif

endmodule

FILE: rtl/csv_record_tokenizer.sv
// top level of the csv record tokenizer: front end, word queue, back end
// depends on csvt_pkg, csvt_front, csvt_queue, csvt_back
//
//  channel  handshake             payload
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//  s        s_valid/s_ready       s_in_byte
//  m        m_valid/m_ready       m_kind, m_column_index, m_character, m_last_of_step
//
// one byte per cycle enters while s_ready is high; the front end updates the record state in that cycle
// a byte yields zero to two words; the back end sends one word per cycle while m_ready is high, so
// sustained rate is one byte per cycle while bytes average at most one word
// s_ready drops only when the four-entry queue is full; cfg_ready is always high
// synchronous active-low reset restores both registers and a fresh record
module csv_record_tokenizer
    import csvt_pkg::*;
#(
    parameter int unsigned FIELD_CAPACITY = FIELD_CAPACITY_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_in_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_kind,
    output logic [3:0]             m_column_index,
    output logic [7:0]             m_character,
    output logic                   m_last_of_step
);

    logic   push;
    entry_t push_entry;
    logic   q_full;
    logic   q_valid;
    entry_t q_entry;
    logic   pop;

    csvt_front #(
        .FIELD_CAPACITY(FIELD_CAPACITY)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    csvt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop)
    );

    csvt_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_entry        (q_entry),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_column_index (m_column_index),
        .m_character    (m_character),
        .m_last_of_step (m_last_of_step)
    );

endmodule
